// File: sv/sha256_sha224_hash_engine_core_macros.svh
// Assertion macros for the SHA-256/224 engine.
// Depends on nothing; included by the top level.
`ifndef SHA256_SHA224_HASH_ENGINE_CORE_MACROS_SVH
`define SHA256_SHA224_HASH_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define SHA_AST_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lbl failed");

// next-cycle implication
`define SHA_AST_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

// File: sv/sha_pkg.sv
// Types and constants for the SHA-256/224 engine.
// No dependencies.
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam logic MODE_256 = 1'b0;
  localparam logic MODE_224 = 1'b1;
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINAL = 1'b1;

  localparam word_t IV256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam word_t IV224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t iv_word(input logic mode, input logic [2:0] idx);
    return (mode == MODE_224) ? IV224[idx] : IV256[idx];
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: sv/sha256_sha224_hash_engine_core.sv
// SHA-256 / SHA-224 engine: byte absorb, padding, iterative compression, digest out.
// Each absorbed byte is shifted into the block; a full block runs its rounds on one round unit, then a feed step.
// Finalize: pad bytes (9..72) are shifted in, each padded block is compressed, then 28 or 32 digest beats.
// Throughput: 1 byte per cycle while idle; input stalls during compression, padding and digest out.
// Reset (rst_n low, synchronous): SHA-256 mode, chaining words at IV, counts cleared.
// Depends on sha_pkg and sha256_sha224_hash_engine_core_macros.svh.
`include "sha256_sha224_hash_engine_core_macros.svh"
module sha256_sha224_hash_engine_core
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,      // digest_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] data_byte
  input  logic       in_tuser,      // [0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] digest_byte
  output logic       out_tlast      // last_byte
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FEED = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic         mode_r;
  logic [511:0] blk_r;
  logic [5:0]   fill_r;
  logic [60:0]  msg_r;
  logic [63:0]  len_r;
  logic         first_r, lenph_r, fin_r;
  logic [5:0]   rnd_r;
  logic [4:0]   cnt_r;
  word_t        v_r [8];
  word_t        chain_r [8];

  logic       in_acc, out_acc, cfg_acc;
  logic       push_en, len_sel;
  logic [7:0] push_b;
  word_t      w0, w1, w9, w14, wnew, t1, t2, e, a, ch_word;

  // a mode write takes the idle cycle ahead of any input beat
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc  = in_tvalid & in_tready;
  assign cfg_acc = cfg_valid & cfg_ready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc = out_tvalid & out_tready;

  assign ch_word   = chain_r[cnt_r[4:2]];
  assign out_tdata = 8'(ch_word >> {~cnt_r[1:0], 3'b000});
  assign out_tlast = (cnt_r == ((mode_r == MODE_224) ? 5'd27 : 5'd31));

  // padding byte source
  assign len_sel = !first_r && (lenph_r || fill_r == 6'd56);
  always_comb begin
    push_en = 1'b0;
    push_b  = in_tdata;
    if (state_r == ST_IDLE) begin
      push_en = in_acc && (in_tuser == OP_ABSORB);
    end else if (state_r == ST_PAD) begin
      push_en = 1'b1;
      if (first_r) push_b = 8'h80;
      else if (len_sel) push_b = len_r[63:56];
      else push_b = 8'h00;
    end
  end

  // round unit and schedule
  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign wnew = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
              + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;
  assign e = v_r[4];
  assign a = v_r[0];
  assign t1 = v_r[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + ROUND_K[rnd_r] + w0;
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == OP_FINAL) state_nxt = ST_PAD;
        else if (push_en && fill_r == 6'd63) state_nxt = ST_COMP;
      end
      ST_PAD:  if (fill_r == 6'd63) state_nxt = ST_COMP;
      ST_COMP: if (rnd_r == 6'd63) state_nxt = ST_FEED;
      ST_FEED: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (lenph_r) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_OUT:  if (out_acc && out_tlast) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_256;
      fill_r  <= '0;
      msg_r   <= '0;
      first_r <= 1'b0;
      lenph_r <= 1'b0;
      fin_r   <= 1'b0;
      rnd_r   <= '0;
      cnt_r   <= '0;
      blk_r   <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= iv_word(MODE_256, 3'(i));
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        mode_r <= cfg_data;
        fill_r <= '0;
        msg_r  <= '0;
        blk_r  <= '0;
        for (int i = 0; i < 8; i++) chain_r[i] <= iv_word(cfg_data, 3'(i));
      end
      if (in_acc && in_tuser == OP_FINAL) begin
        fin_r   <= 1'b1;
        first_r <= 1'b1;
        lenph_r <= 1'b0;
        len_r   <= {msg_r, 3'b000};
      end
      if (in_acc && in_tuser == OP_ABSORB) msg_r <= msg_r + 61'd1;
      if (push_en) begin
        blk_r  <= {blk_r[503:0], push_b};
        fill_r <= fill_r + 6'd1;
        if (state_r == ST_PAD) begin
          first_r <= 1'b0;
          if (len_sel) begin
            lenph_r <= 1'b1;
            len_r   <= {len_r[55:0], 8'h00};
          end
        end
        if (fill_r == 6'd63) begin
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
        end
      end
      if (state_r == ST_COMP) begin
        rnd_r  <= rnd_r + 6'd1;
        blk_r  <= {blk_r[479:0], wnew};
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (state_r == ST_FEED) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
        cnt_r <= '0;
      end
      if (out_acc) begin
        cnt_r <= cnt_r + 5'd1;
        if (out_tlast) begin
          fin_r   <= 1'b0;
          lenph_r <= 1'b0;
          fill_r  <= '0;
          msg_r   <= '0;
          blk_r   <= '0;
          for (int i = 0; i < 8; i++) chain_r[i] <= iv_word(mode_r, 3'(i));
        end
      end
    end
  end

  `SHA_AST_IMP(a_out_blocks_in, clk, rst_n, out_tvalid, !in_tready && !cfg_ready)
  `SHA_AST_NXT(a_rounds_run, clk, rst_n, state_r == ST_COMP && rnd_r != 6'd63, state_r == ST_COMP)
  `SHA_AST_NXT(a_last_frees, clk, rst_n, out_acc && out_tlast, cfg_ready)

endmodule
